### rtl/jfci_pkg.sv
`default_nettype none

package jfci_pkg;

	localparam int unsigned FLASH_BYTES  = 524288;
	localparam int unsigned SECTOR_BYTES = 4096;

	localparam int unsigned ADDR_W  = 19;
	localparam int unsigned TICK_W  = 20;
	localparam int unsigned CFG_IDX_W = 3;

	// bus functions
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MANUF_ID      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_TICKS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHIP_TICKS    = 3'd4;

	// configuration reset values
	localparam logic [7:0]        RST_MANUF_ID      = 8'hBF;
	localparam logic [7:0]        RST_DEVICE_ID     = 8'hB7;
	localparam logic [TICK_W-1:0] RST_PROGRAM_TICKS = 20'd160;
	localparam logic [TICK_W-1:0] RST_SECTOR_TICKS  = 20'd200000;
	localparam logic [TICK_W-1:0] RST_CHIP_TICKS    = 20'd800000;

	// command sequence
	localparam logic [14:0] CMD_ADDR_A   = 15'h5555;
	localparam logic [14:0] CMD_ADDR_B   = 15'h2AAA;
	localparam logic [7:0]  UNLOCK_A     = 8'hAA;
	localparam logic [7:0]  UNLOCK_B     = 8'h55;
	localparam logic [3:0]  OP_PROGRAM   = 4'hA;
	localparam logic [3:0]  OP_ERASE     = 4'h8;
	localparam logic [3:0]  OP_SOFTID    = 4'h9;
	localparam logic [7:0]  ERASE_CHIP   = 8'h10;
	localparam logic [7:0]  ERASE_SECTOR = 8'h30;
	localparam logic [7:0]  ERASED_BYTE  = 8'hFF;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       access_done;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/jfci_ram.sv
`default_nettype none

module jfci_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/jedec_flash_command_interface.sv
`default_nettype none

// Byte-wide JEDEC NOR flash model with the unlock command sequence, array held in
// one single-port-read, single-port-write RAM. For a read or write request, the
// accept cycle issues the array read, the next cycle gets the data back and issues
// the response and any program write-back; a response waits there while the output
// is stalled. A tick passes through the same states and gives no response.
// Erases walk the array one byte per clock with the input stalled: a sector erase
// clears SECTOR_BYTES bytes, a chip erase FLASH_BYTES bytes. After reset the same
// walk fills the whole array with 0xFF, so no request is taken until that walk
// ends. Configuration writes are always ready and take effect at once.

module jedec_flash_command_interface #(
	parameter int unsigned FLASH_BYTES  = jfci_pkg::FLASH_BYTES,
	parameter int unsigned SECTOR_BYTES = jfci_pkg::SECTOR_BYTES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire jfci_pkg::req_t                     in_req,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output jfci_pkg::rsp_t                          out_rsp,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [jfci_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [jfci_pkg::TICK_W-1:0]        cfg_data
);

	localparam int unsigned AW = $clog2(FLASH_BYTES);
	localparam int unsigned SW = $clog2(SECTOR_BYTES);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_P1,
		PH_P2,
		PH_P3,
		PH_P4,
		PH_P5,
		PH_SOFTID,
		PH_BUSY
	} phase_t;

	state_t                         state_q;
	phase_t                         phase_q;
	phase_t                         phase_d;
	logic                           pend_q;
	logic                           pend_d;
	logic [jfci_pkg::TICK_W-1:0]    cnt_q;
	logic [jfci_pkg::TICK_W-1:0]    cnt_d;
	logic                           tog_q;
	jfci_pkg::req_t                 req_s1;
	logic                           out_valid_q;
	jfci_pkg::rsp_t                 out_q;
	logic [AW-1:0]                  clr_addr_q;
	logic [AW-1:0]                  clr_end_q;

	logic [7:0]                     manuf_id_q;
	logic [7:0]                     device_id_q;
	logic [jfci_pkg::TICK_W-1:0]    program_ticks_q;
	logic [jfci_pkg::TICK_W-1:0]    sector_ticks_q;
	logic [jfci_pkg::TICK_W-1:0]    chip_ticks_q;

	logic                           accept;
	logic                           has_rsp;
	logic                           go;
	logic [AW-1:0]                  idx_s1;
	logic                           addr_a;
	logic                           addr_b;
	logic                           prog_we;
	logic                           erase_go;
	logic                           erase_chip;
	logic [7:0]                     read_byte;

	logic                           ram_we;
	logic [AW-1:0]                  ram_wr_addr;
	logic [7:0]                     ram_wr_data;
	logic [7:0]                     ram_rd_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;
	assign cfg_ready = 1'b1;

	assign idx_s1  = AW'(req_s1.address);
	assign addr_a  = (req_s1.address[14:0] == jfci_pkg::CMD_ADDR_A);
	assign addr_b  = (req_s1.address[14:0] == jfci_pkg::CMD_ADDR_B);
	assign has_rsp = (req_s1.func == jfci_pkg::FUNC_READ) ||
		(req_s1.func == jfci_pkg::FUNC_WRITE);
	assign go = (state_q == ST_EXEC) && (!has_rsp || !out_valid_q || !out_stall);

	// command sequencer for a bus write
	always_comb begin
		phase_d    = PH_NORMAL;
		pend_d     = pend_q;
		cnt_d      = '0;
		prog_we    = 1'b0;
		erase_go   = 1'b0;
		erase_chip = 1'b0;
		unique case (phase_q)
			PH_NORMAL: begin
				if (addr_a && req_s1.write_data == jfci_pkg::UNLOCK_A) begin
					phase_d = PH_P1;
				end
			end
			PH_P1, PH_P4: begin
				if (addr_b && req_s1.write_data == jfci_pkg::UNLOCK_B) begin
					phase_d = (phase_q == PH_P1) ? PH_P2 : PH_P5;
				end
			end
			PH_P2: begin
				if (addr_a) begin
					unique case (req_s1.write_data[7:4])
						jfci_pkg::OP_PROGRAM: begin
							pend_d  = 1'b1;
							phase_d = PH_P3;
						end
						jfci_pkg::OP_ERASE: begin
							pend_d  = 1'b0;
							phase_d = PH_P3;
						end
						jfci_pkg::OP_SOFTID: begin
							phase_d = PH_SOFTID;
						end
						default: begin
							phase_d = PH_NORMAL;
						end
					endcase
				end
			end
			PH_P3: begin
				if (pend_q) begin
					prog_we = 1'b1;
					phase_d = PH_BUSY;
					cnt_d   = program_ticks_q;
				end else if (addr_a && req_s1.write_data == jfci_pkg::UNLOCK_A) begin
					phase_d = PH_P4;
				end
			end
			PH_P5: begin
				if (addr_a && req_s1.write_data == jfci_pkg::ERASE_CHIP) begin
					erase_go   = 1'b1;
					erase_chip = 1'b1;
					phase_d    = PH_BUSY;
					cnt_d      = chip_ticks_q;
				end else if (req_s1.write_data == jfci_pkg::ERASE_SECTOR) begin
					erase_go = 1'b1;
					phase_d  = PH_BUSY;
					cnt_d    = sector_ticks_q;
				end
			end
			default: begin
				phase_d = PH_NORMAL;
			end
		endcase
	end

	always_comb begin
		if (phase_q == PH_SOFTID) begin
			read_byte = req_s1.address[0] ? device_id_q : manuf_id_q;
		end else if (phase_q == PH_BUSY) begin
			read_byte = {~ram_rd_data[7], ~tog_q, 6'b0};
		end else begin
			read_byte = ram_rd_data;
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we      = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = jfci_pkg::ERASED_BYTE;
		end else begin
			ram_we      = go && (req_s1.func == jfci_pkg::FUNC_WRITE) && prog_we;
			ram_wr_addr = idx_s1;
			ram_wr_data = ram_rd_data & req_s1.write_data;
		end
	end

	jfci_ram #(
		.WIDTH (8),
		.DEPTH (FLASH_BYTES)
	) u_array (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.re      (accept),
		.rd_addr (AW'(in_req.address)),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manuf_id_q      <= jfci_pkg::RST_MANUF_ID;
			device_id_q     <= jfci_pkg::RST_DEVICE_ID;
			program_ticks_q <= jfci_pkg::RST_PROGRAM_TICKS;
			sector_ticks_q  <= jfci_pkg::RST_SECTOR_TICKS;
			chip_ticks_q    <= jfci_pkg::RST_CHIP_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jfci_pkg::CFG_MANUF_ID:      manuf_id_q      <= cfg_data[7:0];
				jfci_pkg::CFG_DEVICE_ID:     device_id_q     <= cfg_data[7:0];
				jfci_pkg::CFG_PROGRAM_TICKS: program_ticks_q <= cfg_data;
				jfci_pkg::CFG_SECTOR_TICKS:  sector_ticks_q  <= cfg_data;
				jfci_pkg::CFG_CHIP_TICKS:    chip_ticks_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_NORMAL;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			tog_q       <= 1'b0;
			req_s1      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			clr_addr_q  <= '0;
			clr_end_q   <= '1;
		end else begin
			if (out_valid_q && !out_stall && !(go && has_rsp)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == clr_end_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_s1  <= in_req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						unique case (req_s1.func)
							jfci_pkg::FUNC_READ: begin
								state_q           <= ST_IDLE;
								out_valid_q       <= 1'b1;
								out_q.read_data   <= read_byte;
								out_q.access_done <= 1'b1;
								if (phase_q == PH_BUSY) begin
									tog_q <= ~tog_q;
								end
							end
							jfci_pkg::FUNC_WRITE: begin
								out_valid_q       <= 1'b1;
								out_q.read_data   <= '0;
								out_q.access_done <= 1'b1;
								phase_q           <= phase_d;
								pend_q            <= pend_d;
								cnt_q             <= cnt_d;
								if (erase_go) begin
									state_q <= ST_CLEAR;
									if (erase_chip) begin
										clr_addr_q <= '0;
										clr_end_q  <= '1;
									end else begin
										clr_addr_q <= {idx_s1[AW-1:SW], {SW{1'b0}}};
										clr_end_q  <= {idx_s1[AW-1:SW], {SW{1'b1}}};
									end
								end else begin
									state_q <= ST_IDLE;
								end
							end
							jfci_pkg::FUNC_TICK: begin
								state_q <= ST_IDLE;
								if (phase_q == PH_BUSY) begin
									if (cnt_q <= jfci_pkg::TICK_W'(1)) begin
										cnt_q   <= '0;
										phase_q <= PH_NORMAL;
									end else begin
										cnt_q <= cnt_q - jfci_pkg::TICK_W'(1);
									end
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_array_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("array written while idle");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

	a_softid_not_counting: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SOFTID) |-> (cnt_q == '0))
		else $error("busy count running in software id mode");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_addr_q == clr_end_q) |=> (state_q == ST_IDLE))
		else $error("erase walk overran its range");

	a_rsp_only_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EXEC))
		else $error("response without an executed request");

endmodule

`default_nettype wire
